// File: sv/cpc_pkg.sv
// ----------------------------------------------------------------------------
// Collinear points checker package
// Widths, reset values and stage payload types for the checker pipeline.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Point geometry
  localparam int unsigned MAX_DIMS   = 16;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DIMS_W     = 5;
  localparam int unsigned IDX_W      = $clog2(MAX_DIMS);

  // Arithmetic widths: |a-b| of two coordinates fits COORD_BITS unsigned bits,
  // a sum of MAX_DIMS squares needs IDX_W more bits than one square.
  localparam int unsigned MAG_W  = COORD_BITS;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned ACC_W  = SQ_W + IDX_W;
  localparam int unsigned HALF_W = (ACC_W + 1) / 2;
  localparam int unsigned OPD_W  = 2 * HALF_W;
  localparam int unsigned PP_W   = 2 * HALF_W;
  localparam int unsigned PROD_W = 2 * OPD_W;

  // Three ways a triple can be degenerate
  localparam int unsigned NUM_TESTS = 3;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);
  localparam logic [1:0]        PTS_FULL   = 2'd3;
  localparam logic [1:0]        PTS_TRIPLE = 2'd2;

  // Squared coordinate differences of one beat
  typedef struct packed {
    logic [SQ_W-1:0] sq_on;
    logic [SQ_W-1:0] sq_nc;
    logic [SQ_W-1:0] sq_oc;
    logic            done;
    logic            last;
    logic            chk;
  } sq_stage_t;

  // Finished distances of one triple
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic [ACC_W-1:0] c;
    logic             last;
    logic             chk;
  } abc_stage_t;

  typedef struct packed {
    logic [NUM_TESTS-1:0][ACC_W-1:0] t;
    logic [NUM_TESTS-1:0][ACC_W-1:0] y;
    logic [NUM_TESTS-1:0][ACC_W-1:0] z;
    logic [NUM_TESTS-1:0]            ge;
    logic                            last;
    logic                            chk;
  } prep_stage_t;

  // Four partial products of one split multiplication
  typedef struct packed {
    logic [PP_W-1:0] hh;
    logic [PP_W-1:0] hl;
    logic [PP_W-1:0] lh;
    logic [PP_W-1:0] ll;
  } pp_t;

  typedef struct packed {
    pp_t [NUM_TESTS-1:0] tt;
    pp_t [NUM_TESTS-1:0] yz;
    logic [NUM_TESTS-1:0] ge;
    logic                 last;
    logic                 chk;
  } part_stage_t;

  typedef struct packed {
    logic [NUM_TESTS-1:0][PROD_W-1:0] tt;
    logic [NUM_TESTS-1:0][PROD_W-1:0] yz;
    logic [NUM_TESTS-1:0]             ge;
    logic                             last;
    logic                             chk;
  } prod_stage_t;

endpackage

// File: sv/collinear_points_checker_top.sv
// ----------------------------------------------------------------------------
// Collinear points checker
// Streams point coordinates in, checks every run of three consecutive points
// for collinearity with exact integer arithmetic, emits one verdict per list.
// ----------------------------------------------------------------------------
// Feed one signed coordinate per beat on s_axis, dims beats per point, and
// hold s_axis_tlast high on the coordinates of the final point. The block
// takes one beat every clock cycle; ready drops only when a verdict is stuck
// behind a stalled m_axis and the four-deep check pipeline has filled. The
// coordinate stage reads the two held points and forms three squared
// differences, which the accumulate stage adds into the triple accumulators;
// each finished point then walks through the check pipeline (difference,
// split partial products, product sum, compare) into the output register
// that drives the verdict beat on m_axis. A verdict of collinear = 1 means
// every consecutive triple had one distance equal to the sum of the other
// two; status = 1 flags a list of fewer than three points (collinear is then
// 0). Write dims on the cfg port only while no list is being streamed into
// a pending verdict; 0 acts as 1 and values above 16 act as 16.
// ----------------------------------------------------------------------------
module collinear_points_checker_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // coordinate stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] coord
  input  logic                               s_axis_tlast,  // last_point
  // verdict stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [0] collinear, [1] status
  // dims register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cpc_pkg::DIMS_W-1:0]         cfg_data_i
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Magnitude of the difference of two coordinates
  function automatic logic [cpc_pkg::MAG_W-1:0] abs_diff(
    input logic [cpc_pkg::COORD_BITS-1:0] x,
    input logic [cpc_pkg::COORD_BITS-1:0] y
  );
    logic [cpc_pkg::COORD_BITS:0] d;
    logic [cpc_pkg::COORD_BITS:0] m;
    d = {x[cpc_pkg::COORD_BITS-1], x} - {y[cpc_pkg::COORD_BITS-1], y};
    m = d[cpc_pkg::COORD_BITS] ? (~d + 1'b1) : d;
    return m[cpc_pkg::MAG_W-1:0];
  endfunction

  // Split one wide multiplication into four half-width partial products
  function automatic cpc_pkg::pp_t mul_split(
    input logic [cpc_pkg::ACC_W-1:0] a,
    input logic [cpc_pkg::ACC_W-1:0] b
  );
    logic [cpc_pkg::OPD_W-1:0]  ae;
    logic [cpc_pkg::OPD_W-1:0]  be;
    logic [cpc_pkg::HALF_W-1:0] al, ah, bl, bh;
    cpc_pkg::pp_t               p;
    ae = cpc_pkg::OPD_W'(a);
    be = cpc_pkg::OPD_W'(b);
    al = ae[cpc_pkg::HALF_W-1:0];
    ah = ae[cpc_pkg::OPD_W-1:cpc_pkg::HALF_W];
    bl = be[cpc_pkg::HALF_W-1:0];
    bh = be[cpc_pkg::OPD_W-1:cpc_pkg::HALF_W];
    p.ll = cpc_pkg::PP_W'(al) * cpc_pkg::PP_W'(bl);
    p.lh = cpc_pkg::PP_W'(al) * cpc_pkg::PP_W'(bh);
    p.hl = cpc_pkg::PP_W'(ah) * cpc_pkg::PP_W'(bl);
    p.hh = cpc_pkg::PP_W'(ah) * cpc_pkg::PP_W'(bh);
    return p;
  endfunction

  // Recombine partial products into the full product
  function automatic logic [cpc_pkg::PROD_W-1:0] pp_sum(input cpc_pkg::pp_t p);
    return cpc_pkg::PROD_W'(p.ll)
         + (cpc_pkg::PROD_W'(p.lh) << cpc_pkg::HALF_W)
         + (cpc_pkg::PROD_W'(p.hl) << cpc_pkg::HALF_W)
         + (cpc_pkg::PROD_W'(p.hh) << cpc_pkg::OPD_W);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: dims register, always ready
  // --------------------------------------------------------------------------
  logic [cpc_pkg::DIMS_W-1:0] dims_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= cpc_pkg::DIMS_RESET;
    end else if (cfg_valid_i) begin
      dims_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage takes a new entry when it is empty or its
  // entry moves on. The last stage only blocks on a verdict that cannot enter
  // the output register.
  // --------------------------------------------------------------------------
  logic                 v1_q, v_abc_q, v_prep_q, v_part_q, v_prod_q;
  logic                 rdy1, rdy_abc, rdy_prep, rdy_part, rdy_prod;
  logic                 go_acc, res_fire, in_fire;
  logic                 m_tvalid_q;
  cpc_pkg::sq_stage_t   s1_q, s1_d;
  cpc_pkg::abc_stage_t  abc_q, abc_d;
  cpc_pkg::prep_stage_t prep_q, prep_d;
  cpc_pkg::part_stage_t part_q, part_d;
  cpc_pkg::prod_stage_t prod_q, prod_d;

  assign rdy_prod = !v_prod_q || !prod_q.last || !m_tvalid_q || m_axis_tready;
  assign rdy_part = !v_part_q || rdy_prod;
  assign rdy_prep = !v_prep_q || rdy_part;
  assign rdy_abc  = !v_abc_q  || rdy_prep;
  assign go_acc   = v1_q && (!s1_q.done || rdy_abc);
  assign rdy1     = !v1_q || go_acc;
  assign res_fire = v_prod_q && rdy_prod;

  assign s_axis_tready = rdy1;
  assign in_fire       = s_axis_tvalid && rdy1;

  // --------------------------------------------------------------------------
  // Coordinate stage: read the held points at the current index, form the
  // three squared differences, shift the current coordinate in.
  // --------------------------------------------------------------------------
  logic [cpc_pkg::COORD_BITS-1:0] older_q [cpc_pkg::MAX_DIMS];
  logic [cpc_pkg::COORD_BITS-1:0] newer_q [cpc_pkg::MAX_DIMS];
  logic [cpc_pkg::IDX_W-1:0]      idx_q;
  logic [1:0]                     pts_q;
  logic [cpc_pkg::IDX_W-1:0]      dim_last;
  logic [cpc_pkg::IDX_W-1:0]      ci;
  logic [cpc_pkg::COORD_BITS-1:0] cur, older_cur, newer_cur;
  logic [cpc_pkg::MAG_W-1:0]      mag_on, mag_nc, mag_oc;
  logic                           pt_done;

  // Clamp dims to 1..MAX_DIMS, keep it as "index of last coordinate"
  always_comb begin
    if (dims_q == '0) begin
      dim_last = '0;
    end else if (dims_q > cpc_pkg::DIMS_W'(cpc_pkg::MAX_DIMS)) begin
      dim_last = cpc_pkg::IDX_W'(cpc_pkg::MAX_DIMS - 1);
    end else begin
      dim_last = cpc_pkg::IDX_W'(dims_q - 1'b1);
    end
  end

  // A shrunk dims completes the point at once
  assign ci        = (idx_q > dim_last) ? dim_last : idx_q;
  assign pt_done   = (ci == dim_last);
  assign cur       = s_axis_tdata[cpc_pkg::COORD_BITS-1:0];
  assign older_cur = older_q[ci];
  assign newer_cur = newer_q[ci];
  assign mag_on    = abs_diff(older_cur, newer_cur);
  assign mag_nc    = abs_diff(newer_cur, cur);
  assign mag_oc    = abs_diff(older_cur, cur);

  always_comb begin
    s1_d.sq_on = mag_on * mag_on;
    s1_d.sq_nc = mag_nc * mag_nc;
    s1_d.sq_oc = mag_oc * mag_oc;
    s1_d.done  = pt_done;
    s1_d.last  = pt_done && s_axis_tlast;
    s1_d.chk   = (pts_q >= cpc_pkg::PTS_TRIPLE);
  end

  // Point history and list position; drop the whole list after its final coordinate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '{default: '0};
      newer_q <= '{default: '0};
      idx_q   <= '0;
      pts_q   <= '0;
    end else if (in_fire) begin
      if (pt_done && s_axis_tlast) begin
        older_q <= '{default: '0};
        newer_q <= '{default: '0};
        idx_q   <= '0;
        pts_q   <= '0;
      end else begin
        older_q[ci] <= newer_cur;
        newer_q[ci] <= cur;
        if (pt_done) begin
          idx_q <= '0;
          if (pts_q != cpc_pkg::PTS_FULL) begin
            pts_q <= pts_q + 1'b1;
          end
        end else begin
          idx_q <= ci + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate stage: add squares into the triple distances; a finished point
  // hands its distances to the check pipeline and clears the accumulators.
  // --------------------------------------------------------------------------
  logic [cpc_pkg::ACC_W-1:0] acc_on_q, acc_nc_q, acc_oc_q;
  logic [cpc_pkg::ACC_W-1:0] sum_on, sum_nc, sum_oc;

  assign sum_on = acc_on_q + (s1_q.chk ? cpc_pkg::ACC_W'(s1_q.sq_on) : '0);
  assign sum_nc = acc_nc_q + (s1_q.chk ? cpc_pkg::ACC_W'(s1_q.sq_nc) : '0);
  assign sum_oc = acc_oc_q + (s1_q.chk ? cpc_pkg::ACC_W'(s1_q.sq_oc) : '0);

  always_comb begin
    abc_d.a    = sum_on;
    abc_d.b    = sum_nc;
    abc_d.c    = sum_oc;
    abc_d.last = s1_q.last;
    abc_d.chk  = s1_q.chk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_on_q <= '0;
      acc_nc_q <= '0;
      acc_oc_q <= '0;
    end else if (go_acc) begin
      if (s1_q.done) begin
        acc_on_q <= '0;
        acc_nc_q <= '0;
        acc_oc_q <= '0;
      end else begin
        acc_on_q <= sum_on;
        acc_nc_q <= sum_nc;
        acc_oc_q <= sum_oc;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Prep stage: for x = y + z test t = x - y - z >= 0, keep t, y, z
  // --------------------------------------------------------------------------
  logic [cpc_pkg::NUM_TESTS-1:0][cpc_pkg::ACC_W-1:0] tx, ty, tz;

  always_comb begin
    tx = {abc_q.c, abc_q.b, abc_q.a};
    ty = {abc_q.a, abc_q.a, abc_q.b};
    tz = {abc_q.b, abc_q.c, abc_q.c};
    for (int k = 0; k < cpc_pkg::NUM_TESTS; k++) begin
      prep_d.ge[k] = (tx[k] >= ty[k]) && ((tx[k] - ty[k]) >= tz[k]);
      prep_d.t[k]  = tx[k] - ty[k] - tz[k];
    end
    prep_d.y    = ty;
    prep_d.z    = tz;
    prep_d.last = abc_q.last;
    prep_d.chk  = abc_q.chk;
  end

  // --------------------------------------------------------------------------
  // Partial product stage, then product sum stage
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < cpc_pkg::NUM_TESTS; k++) begin
      part_d.tt[k] = mul_split(prep_q.t[k], prep_q.t[k]);
      part_d.yz[k] = mul_split(prep_q.y[k], prep_q.z[k]);
    end
    part_d.ge   = prep_q.ge;
    part_d.last = prep_q.last;
    part_d.chk  = prep_q.chk;
  end

  always_comb begin
    for (int k = 0; k < cpc_pkg::NUM_TESTS; k++) begin
      prod_d.tt[k] = pp_sum(part_q.tt[k]);
      prod_d.yz[k] = pp_sum(part_q.yz[k]);
    end
    prod_d.ge   = part_q.ge;
    prod_d.last = part_q.last;
    prod_d.chk  = part_q.chk;
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v_abc_q  <= 1'b0;
      v_prep_q <= 1'b0;
      v_part_q <= 1'b0;
      v_prod_q <= 1'b0;
    end else begin
      if (rdy1)     v1_q     <= s_axis_tvalid;
      if (rdy_abc)  v_abc_q  <= go_acc && s1_q.done;
      if (rdy_prep) v_prep_q <= v_abc_q;
      if (rdy_part) v_part_q <= v_prep_q;
      if (rdy_prod) v_prod_q <= v_part_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_fire)                        s1_q   <= s1_d;
    if (rdy_abc && go_acc && s1_q.done) abc_q  <= abc_d;
    if (rdy_prep && v_abc_q)            prep_q <= prep_d;
    if (rdy_part && v_prep_q)           part_q <= part_d;
    if (rdy_prod && v_part_q)           prod_q <= prod_d;
  end

  // --------------------------------------------------------------------------
  // Compare stage: t*t == 4*y*z, fold into the running verdict, emit the
  // verdict beat on the list's last point.
  // --------------------------------------------------------------------------
  logic [cpc_pkg::NUM_TESTS-1:0] eq;
  logic                          pass, verdict, all_q;
  logic [1:0]                    res_d, res_q;

  always_comb begin
    for (int k = 0; k < cpc_pkg::NUM_TESTS; k++) begin
      eq[k] = ({2'b00, prod_q.tt[k]} == {prod_q.yz[k], 2'b00});
    end
  end

  assign pass    = |(prod_q.ge & eq);
  assign verdict = all_q && pass;
  // bit 0 collinear, bit 1 status (too few points)
  assign res_d   = prod_q.chk ? {1'b0, verdict} : 2'b10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q      <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      if (res_fire) begin
        if (prod_q.last) begin
          all_q <= 1'b1;
        end else if (prod_q.chk) begin
          all_q <= verdict;
        end
      end
      if (res_fire && prod_q.last) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire && prod_q.last) res_q <= res_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = cpc_pkg::OUT_DATA_W'(res_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_list_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && pt_done && s_axis_tlast) |=> (idx_q == '0 && pts_q == '0))
    else $error("list state not cleared after final point");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_acc && s1_q.done) |=> (acc_on_q == '0 && acc_nc_q == '0 && acc_oc_q == '0))
    else $error("accumulators not cleared after finished point");

  a_verdict_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && prod_q.last) |=> all_q)
    else $error("running verdict not rearmed after emitted beat");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_fire && prod_q.last))
    else $error("verdict beat raised without a finished list");

endmodule

// File: tb/collinear_points_checker_top_test.sv
// ----------------------------------------------------------------------------
// Collinear points checker testbench
// Streams lists of points through the checker and compares every verdict beat
// with an in-bench tracker of the point triples. A short table of directed
// lists comes first, then random lists: half collinear point sets with
// random base and direction, some with one point nudged off the line, some
// fully random, and some too short to form a triple. dims is rewritten
// between phases, once all pending verdicts have drained.
// ----------------------------------------------------------------------------
module collinear_points_checker_top_test;

  localparam logic        STATUS_VALID   = 1'b0;
  localparam logic        STATUS_TOO_FEW = 1'b1;
  localparam int unsigned ITEM_TARGET    = 1400;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 12;

  typedef struct packed {
    logic collinear;
    logic status;
  } verdict_t;

  typedef struct packed {
    logic [15:0] coord;
    logic        last;
    logic        typed;
    logic        collinear;
    logic        status;
  } directed_row_t;

  // dims is 2 after reset; the verdict is typed in only for the short lists
  localparam int unsigned NUM_ROWS = 24;
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // one point, tlast also on its first coordinate
    '{16'h0005, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'h0007, 1'b1, 1'b1, 1'b0, STATUS_TOO_FEW},
    // two points at the coordinate extremes
    '{16'h8000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'h8000, 1'b1, 1'b1, 1'b0, STATUS_TOO_FEW},
    // three coincident points
    '{16'h0003, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'hFFFD, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h0003, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'hFFFD, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h0003, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'hFFFD, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    // right triangle spanning the full coordinate range
    '{16'h8000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h8000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h8000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    // full-range diagonal, stray tlast on an early coordinate
    '{16'h8000, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'h8000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h0000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h0000, 1'b0, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, STATUS_VALID},
    '{16'h7FFF, 1'b1, 1'b0, 1'b0, STATUS_VALID}
  };

  localparam logic [cpc_pkg::DIMS_W-1:0] DIMS_PLAN [7] = '{
    cpc_pkg::DIMS_W'(1), cpc_pkg::DIMS_W'(16), cpc_pkg::DIMS_W'(0),
    cpc_pkg::DIMS_W'(31), cpc_pkg::DIMS_W'(17), cpc_pkg::DIMS_W'(3),
    cpc_pkg::DIMS_W'(2)
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [cpc_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] coord
  logic                           s_axis_tlast  = 1'b0;  // last_point
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [cpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [0] collinear, [1] status
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [cpc_pkg::DIMS_W-1:0]     cfg_data_i    = '0;

  collinear_points_checker_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Triple tracker state
  logic [cpc_pkg::DIMS_W-1:0] dims_cfg;
  logic signed [15:0]         held_old [cpc_pkg::MAX_DIMS];
  logic signed [15:0]         held_new [cpc_pkg::MAX_DIMS];
  int unsigned                at_coord;
  int unsigned                pts_done;
  logic [63:0]                dist_on;
  logic [63:0]                dist_nc;
  logic [63:0]                dist_oc;
  bit                         all_on_line;

  verdict_t    verdict_q [$];
  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  function automatic void clear_track();
    for (int i = 0; i < cpc_pkg::MAX_DIMS; i++) begin
      held_old[i] = '0;
      held_new[i] = '0;
    end
    at_coord    = 0;
    pts_done    = 0;
    dist_on     = '0;
    dist_nc     = '0;
    dist_oc     = '0;
    all_on_line = 1'b1;
  endfunction

  function automatic logic [63:0] sq_gap(logic signed [15:0] a, logic signed [15:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return 64'(d * d);
  endfunction

  // Distance x equals y plus z when x-y-z >= 0 and (x-y-z)^2 == 4*y*z
  function automatic bit is_sum(logic [63:0] x, logic [63:0] y, logic [63:0] z);
    logic [127:0] t;
    logic [127:0] yz;
    if (x < y || x - y < z) return 1'b0;
    t  = {64'd0, x - y - z};
    yz = {64'd0, y} * {64'd0, z};
    return (t * t) == (yz << 2);
  endfunction

  // Advance the tracker by one coordinate; returns 1 when a verdict is due
  function automatic bit step_points(logic [15:0] raw, logic fin, output verdict_t v);
    int unsigned d;
    int unsigned ci;
    d = (dims_cfg == 0) ? 1 :
        ((dims_cfg > cpc_pkg::MAX_DIMS) ? cpc_pkg::MAX_DIMS : dims_cfg);
    ci = (at_coord > d - 1) ? d - 1 : at_coord;
    v = '0;
    if (pts_done >= 2) begin
      dist_on += sq_gap(held_old[ci], held_new[ci]);
      dist_nc += sq_gap(held_new[ci], raw);
      dist_oc += sq_gap(held_old[ci], raw);
    end
    held_old[ci] = held_new[ci];
    held_new[ci] = raw;
    if (ci < d - 1) begin
      at_coord = ci + 1;
      return 1'b0;
    end
    at_coord = 0;
    if (pts_done >= 2 && !(is_sum(dist_on, dist_nc, dist_oc) ||
        is_sum(dist_nc, dist_on, dist_oc) || is_sum(dist_oc, dist_on, dist_nc)))
      all_on_line = 1'b0;
    dist_on = '0;
    dist_nc = '0;
    dist_oc = '0;
    if (pts_done < 3) pts_done++;
    if (!fin) return 1'b0;
    if (pts_done < 3) begin
      v.collinear = 1'b0;
      v.status    = STATUS_TOO_FEW;
    end else begin
      v.collinear = all_on_line;
      v.status    = STATUS_VALID;
    end
    clear_track();
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Drive one coordinate beat, idling before it now and then
  task automatic put_coord(logic [15:0] val, logic fin, bit typed, verdict_t typed_v);
    verdict_t v;
    if (!calm && $urandom_range(0, 99) < 4) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (step_points(val, fin, v)) verdict_q.push_back(typed ? typed_v : v);
  endtask

  // Drain pending verdicts, let the pipeline settle, then write dims
  task automatic write_dims(logic [cpc_pkg::DIMS_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dims_cfg = val;
  endtask

  // One list: collinear, collinear with one point nudged off, or random
  task automatic send_list(int unsigned npts);
    int unsigned d;
    int unsigned kind;
    int unsigned bad_pt;
    int          base_pt [cpc_pkg::MAX_DIMS];
    int          step_dir [cpc_pkg::MAX_DIMS];
    int          k;
    bit          flat;
    logic [15:0] val;
    logic        fin;
    d = (dims_cfg == 0) ? 1 :
        ((dims_cfg > cpc_pkg::MAX_DIMS) ? cpc_pkg::MAX_DIMS : dims_cfg);
    kind   = $urandom_range(0, 9);
    flat   = ($urandom_range(0, 7) == 0);
    bad_pt = $urandom_range(0, npts - 1);
    for (int c = 0; c < d; c++) begin
      base_pt[c]  = int'($urandom_range(0, 4000)) - 2000;
      step_dir[c] = flat ? 0 : int'($urandom_range(0, 800)) - 400;
    end
    for (int p = 0; p < npts; p++) begin
      k = int'($urandom_range(0, 16)) - 8;
      for (int c = 0; c < d; c++) begin
        if (kind >= 7) begin
          case ($urandom_range(0, 9))
            0:       val = 16'h8000;
            1:       val = 16'h7FFF;
            default: val = 16'($urandom_range(0, 65535));
          endcase
        end else begin
          val = 16'(base_pt[c] + k * step_dir[c]);
          if (kind >= 5 && p == bad_pt && c == 0) val += 16'($urandom_range(1, 3));
        end
        // tlast on all coordinates of the final point, stray on early ones
        fin = (p == npts - 1) || (c < d - 1 && $urandom_range(0, 19) == 0);
        put_coord(val, fin, 1'b0, '0);
      end
    end
  endtask

  // Output side: stall about one cycle in ten, never while calm
  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Verdict checker: compare each accepted beat with the oldest prediction
  initial begin
    verdict_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict beat 0x%0h with none pending", m_axis_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.collinear)
            flag_mismatch($sformatf("collinear expected %0b actual %0b",
                                    want.collinear, m_axis_tdata[0]));
          if (m_axis_tdata[1] !== want.status)
            flag_mismatch($sformatf("status expected %0b actual %0b",
                                    want.status, m_axis_tdata[1]));
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned npts;
    dims_cfg = cpc_pkg::DIMS_RESET;
    clear_track();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists at the reset dims
    for (int r = 0; r < NUM_ROWS; r++) begin
      put_coord(DIRECTED_ROWS[r].coord, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                '{collinear: DIRECTED_ROWS[r].collinear, status: DIRECTED_ROWS[r].status});
    end

    // Random phases, dims rewritten between them; phase 3 runs without idling
    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      if (phase < 7)
        write_dims(DIMS_PLAN[phase]);
      else if ($urandom_range(0, 5) == 0)
        write_dims(cpc_pkg::DIMS_W'($urandom_range(0, 31)));
      else
        write_dims(cpc_pkg::DIMS_W'($urandom_range(1, 6)));
      calm = (phase == 3);
      for (int l = 0; l < 6; l++) begin
        npts = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        send_list(npts);
      end
      calm = 1'b0;
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
